/* hdl/dbs_pkg.sv */
package dbs_pkg;

   localparam int DIGIT_W = 4;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
   localparam logic [DIGIT_W:0] RADIX = 5'd10;

   localparam logic TYPE_MINUEND = 1'b0;
   localparam logic TYPE_SUBTRAHEND = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_SUBTRACT,
      ST_EMIT_READ,
      ST_EMIT_WAIT
   } state_type;

endpackage

/* hdl/decimal_bignum_subtract_core.sv */
// Digit load: one word per cycle while idle, no response held; overflow gives an error word.
// Last subtrahend word: a magnitude compare pass, then a borrow pass, each over n digits,
// n being the longer operand length; each pass reads both operand memories each cycle.
// Result: per difference word, ST_EMIT_READ (difference memory read), then ST_EMIT_WAIT.
// Reset (reset, synchronous, active high) clears lengths, closed flags, FSM and output valid;
// memory contents are not cleared.
module decimal_bignum_subtract_core #(
   parameter int MAX_DIGITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [3:0] digit, [7:4] zero
   input  logic       req_tuser,  // [0] req_type
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [0] negative, [4:1] result_digit, [7:5] zero
   output logic       rsp_tuser,  // [0] overflow_error
   output logic       rsp_tlast
);

   localparam int LW = $clog2(MAX_DIGITS + 1);
   localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int DW = dbs_pkg::DIGIT_W;

   logic [DW-1:0] mem_a [MAX_DIGITS];
   logic [DW-1:0] mem_b [MAX_DIGITS];
   logic [DW-1:0] mem_d [MAX_DIGITS];

   dbs_pkg::state_type state_ff, state_in;

   logic [LW-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic          closed_a_ff, closed_a_in, closed_b_ff, closed_b_in;
   logic [LW-1:0] n_ff, n_in;
   logic [LW-1:0] place_ff, place_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic          decided_ff, decided_in;
   logic          swap_ff, swap_in;
   logic          borrow_ff, borrow_in;
   logic          zero_ff, zero_in;
   logic [AW-1:0] top_ff, top_in;
   logic [AW-1:0] e_ff, e_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_ina_ff, s1_ina_in, s1_inb_ff, s1_inb_in;
   logic [AW-1:0] s1_place_ff, s1_place_in;
   logic [DW-1:0] ra_ff, rb_ff, rd_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_neg_ff, rsp_neg_in;
   logic [DW-1:0] rsp_digit_ff, rsp_digit_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_err_ff, rsp_err_in;

   logic          req_fire, rsp_free, is_sub, cur_closed, ovf, start, issue, pass_done;
   logic [DW-1:0] d_in, d_clamp;
   logic [LW-1:0] cur_len, len_eff, addr_a_full, addr_b_full;
   logic [AW-1:0] addr_a, addr_b;
   logic [DW-1:0] op_x, op_y, op_t, diff;
   logic [DW:0]   sub5, x5, diff5;
   logic          wr_a, wr_b, wr_d;

   assign req_tready = (state_ff == dbs_pkg::ST_IDLE) && rsp_free;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign is_sub     = (req_tuser == dbs_pkg::TYPE_SUBTRAHEND);
   assign d_in       = req_tdata[DW-1:0];
   assign d_clamp    = (d_in > dbs_pkg::DIGIT_MAX) ? dbs_pkg::DIGIT_MAX : d_in;
   assign cur_len    = is_sub ? len_b_ff : len_a_ff;
   assign cur_closed = is_sub ? closed_b_ff : closed_a_ff;
   assign len_eff    = cur_closed ? '0 : cur_len;
   assign ovf        = (len_eff >= LW'(MAX_DIGITS));
   assign start      = req_fire && !ovf && req_tlast && is_sub;
   assign wr_a       = req_fire && !ovf && !is_sub;
   assign wr_b       = req_fire && !ovf && is_sub;

   assign issue = ((state_ff == dbs_pkg::ST_COMPARE) || (state_ff == dbs_pkg::ST_SUBTRACT))
                  && (rem_ff != '0);
   assign pass_done   = (rem_ff == '0) && !s1_valid_ff;
   assign addr_a_full = len_a_ff - LW'(1) - place_ff;
   assign addr_b_full = len_b_ff - LW'(1) - place_ff;
   assign addr_a      = addr_a_full[AW-1:0];
   assign addr_b      = addr_b_full[AW-1:0];
   assign s1_valid_in = issue;
   assign s1_ina_in   = issue && (place_ff < len_a_ff);
   assign s1_inb_in   = issue && (place_ff < len_b_ff);
   assign s1_place_in = place_ff[AW-1:0];

   assign op_t  = s1_ina_ff ? ra_ff : '0;
   assign op_y  = s1_inb_ff ? rb_ff : '0;
   assign op_x  = op_t;
   assign x5    = swap_ff ? {1'b0, op_y} : {1'b0, op_x};
   assign sub5  = (swap_ff ? {1'b0, op_x} : {1'b0, op_y}) + {{DW{1'b0}}, borrow_ff};
   assign diff5 = (x5 >= sub5) ? (x5 - sub5) : (x5 + dbs_pkg::RADIX - sub5);
   assign diff  = diff5[DW-1:0];
   assign wr_d  = (state_ff == dbs_pkg::ST_SUBTRACT) && s1_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dbs_pkg::ST_IDLE: begin
            if (start) state_in = dbs_pkg::ST_COMPARE;
         end
         dbs_pkg::ST_COMPARE: begin
            if (pass_done) state_in = dbs_pkg::ST_SUBTRACT;
         end
         dbs_pkg::ST_SUBTRACT: begin
            if (pass_done) state_in = dbs_pkg::ST_EMIT_READ;
         end
         dbs_pkg::ST_EMIT_READ: begin
            state_in = dbs_pkg::ST_EMIT_WAIT;
         end
         dbs_pkg::ST_EMIT_WAIT: begin
            if (rsp_free) state_in = (e_ff == '0) ? dbs_pkg::ST_IDLE : dbs_pkg::ST_EMIT_READ;
         end
         default: state_in = dbs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      closed_a_in  = closed_a_ff;
      closed_b_in  = closed_b_ff;
      n_in         = n_ff;
      place_in     = place_ff;
      rem_in       = rem_ff;
      decided_in   = decided_ff;
      swap_in      = swap_ff;
      borrow_in    = borrow_ff;
      zero_in      = zero_ff;
      top_in       = top_ff;
      e_in         = e_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_neg_in   = rsp_neg_ff;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         dbs_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (ovf) begin
                  // drop the word, clear the operand, flag the error
                  if (is_sub) begin
                     len_b_in    = '0;
                     closed_b_in = 1'b0;
                  end else begin
                     len_a_in    = '0;
                     closed_a_in = 1'b0;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_neg_in   = 1'b0;
                  rsp_digit_in = '0;
                  rsp_last_in  = 1'b1;
                  rsp_err_in   = 1'b1;
               end else if (is_sub) begin
                  len_b_in    = len_eff + LW'(1);
                  closed_b_in = req_tlast;
               end else begin
                  len_a_in    = len_eff + LW'(1);
                  closed_a_in = req_tlast;
               end
            end
            if (start) begin
               n_in        = (len_a_in > len_b_in) ? len_a_in : len_b_in;
               place_in    = n_in - LW'(1);
               rem_in      = n_in;
               zero_in     = (n_in == '0);
               decided_in  = 1'b0;
               swap_in     = 1'b0;
               closed_a_in = 1'b1;
               closed_b_in = 1'b1;
            end
         end
         dbs_pkg::ST_COMPARE: begin
            if (issue) begin
               place_in = place_ff - LW'(1);
               rem_in   = rem_ff - LW'(1);
            end
            if (s1_valid_ff && !decided_ff && (op_x != op_y)) begin
               decided_in = 1'b1;
               swap_in    = (op_y > op_x);
            end
            if (pass_done) begin
               place_in  = '0;
               rem_in    = n_ff;
               borrow_in = 1'b0;
               top_in    = '0;
            end
         end
         dbs_pkg::ST_SUBTRACT: begin
            if (issue) begin
               place_in = place_ff + LW'(1);
               rem_in   = rem_ff - LW'(1);
            end
            if (s1_valid_ff) begin
               borrow_in = (x5 < sub5);
               if (diff != '0) top_in = s1_place_ff;
            end
            if (pass_done) e_in = top_ff;
         end
         dbs_pkg::ST_EMIT_WAIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_neg_in   = swap_ff;
               rsp_digit_in = zero_ff ? '0 : rd_ff;
               rsp_last_in  = (e_ff == '0);
               rsp_err_in   = 1'b0;
               if (e_ff != '0) e_in = e_ff - AW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dbs_pkg::ST_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         closed_a_ff  <= 1'b0;
         closed_b_ff  <= 1'b0;
         rem_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         closed_a_ff  <= closed_a_in;
         closed_b_ff  <= closed_b_in;
         rem_ff       <= rem_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      place_ff     <= place_in;
      decided_ff   <= decided_in;
      swap_ff      <= swap_in;
      borrow_ff    <= borrow_in;
      zero_ff      <= zero_in;
      top_ff       <= top_in;
      e_ff         <= e_in;
      s1_ina_ff    <= s1_ina_in;
      s1_inb_ff    <= s1_inb_in;
      s1_place_ff  <= s1_place_in;
      rsp_neg_ff   <= rsp_neg_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (wr_a) mem_a[len_eff[AW-1:0]] <= d_clamp;
      ra_ff <= mem_a[addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_b) mem_b[len_eff[AW-1:0]] <= d_clamp;
      rb_ff <= mem_b[addr_b];
   end

   always_ff @(posedge clock) begin
      if (wr_d) mem_d[s1_place_ff] <= diff;
      if (state_ff == dbs_pkg::ST_EMIT_READ) rd_ff <= mem_d[e_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_digit_ff, rsp_neg_ff};
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_err_word : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == 8'h00))
      else $error("error word carries digit or sign");

   a_digit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:1] <= dbs_pkg::DIGIT_MAX))
      else $error("result digit out of range");

   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      (len_a_ff <= LW'(MAX_DIGITS)) && (len_b_ff <= LW'(MAX_DIGITS)))
      else $error("operand length beyond capacity");

   a_emit_ptr : assert property (@(posedge clock) disable iff (reset)
      (state_ff == dbs_pkg::ST_EMIT_READ || state_ff == dbs_pkg::ST_EMIT_WAIT)
      |-> zero_ff || ({{(LW-AW){1'b0}}, e_ff} < n_ff))
      else $error("emit pointer beyond difference length");
`endif

endmodule
